FILE: rtl/kls_pkg.sv
// ----------------------------------------------------------------------------
// kls_pkg
// Shared constants for the k-th largest stream tracker: register width,
// sequencer state codes and child select codes.
// ----------------------------------------------------------------------------
`default_nettype none

package kls_pkg;

  // width of the rank register
  localparam int K_BITS = 7;

  // sequencer states
  localparam int ST_BITS = 3;
  localparam logic [ST_BITS-1:0] ST_IDLE     = 3'd0;
  localparam logic [ST_BITS-1:0] ST_UP_RD    = 3'd1;
  localparam logic [ST_BITS-1:0] ST_UP_CMP   = 3'd2;
  localparam logic [ST_BITS-1:0] ST_FULL_CMP = 3'd3;
  localparam logic [ST_BITS-1:0] ST_DN_RD    = 3'd4;
  localparam logic [ST_BITS-1:0] ST_DN_L     = 3'd5;
  localparam logic [ST_BITS-1:0] ST_DN_R     = 3'd6;
  localparam logic [ST_BITS-1:0] ST_FINISH   = 3'd7;

  // which entry is the smallest so far during sift down
  localparam int SEL_BITS = 1;
  localparam logic [SEL_BITS-1:0] SEL_SELF = 1'b0;
  localparam logic [SEL_BITS-1:0] SEL_LEFT = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/kls_ram.sv
// ----------------------------------------------------------------------------
// kls_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/kls_cmp.sv
// ----------------------------------------------------------------------------
// kls_cmp
// Shared compare unit: unsigned less-than on sign-biased heap values, with
// the smaller of the two operands.
// ----------------------------------------------------------------------------
`default_nettype none

module kls_cmp #(
  parameter int WIDTH = 32
) (
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  output logic                  lt,
  output logic      [WIDTH-1:0] least
);

  // compare and select the minimum
  always_comb begin
    lt    = (a < b);
    least = lt ? a : b;
  end

endmodule

`default_nettype wire

FILE: rtl/kth_largest_stream_tracker.sv
// ----------------------------------------------------------------------------
// kth_largest_stream_tracker
// Keeps the k largest signed values of a stream in a binary min-heap held in
// a RAM; the heap root is the k-th largest value. One compare unit is shared
// by sift up, the root check and sift down under a small sequencer.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  tdata: sample_value, tuser: preload
//   m_*       out  m_tvalid/m_tready  tdata: kth_value, tuser: heap_full
//   cfg_*     in   cfg_we             cfg_wdata: k_target
//
// While the heap fills, an item enters at the next free slot and climbs
// with one RAM read and one compare per parent. Once full, a value above
// the root replaces it and sifts down, with two reads of the single RAM
// read port and two compares for each level whose node has a child. A
// value not above the root leaves the heap unchanged.
// s_tready is high only in the idle state and out of reset. A finished
// result waits in the output register; the next item is taken meanwhile,
// and the block stalls at its end only if the earlier result has still not
// been taken.
// Reset empties the heap at once; the RAM itself needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module kth_largest_stream_tracker
  import kls_pkg::*;
#(
  parameter int MAX_RANK   = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic [K_BITS-1:0]                    cfg_wdata,
  // input stream
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]      s_tdata,  // sample_value
  input  wire logic                                 s_tuser,  // preload
  // result stream
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic      [((VALUE_BITS+7)/8)*8-1:0]      m_tdata,  // kth_value
  output logic                                      m_tuser   // heap_full
);

  localparam int DW = ((VALUE_BITS + 7) / 8) * 8;
  localparam int VW = VALUE_BITS;
  localparam int AW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int CW = $clog2(MAX_RANK + 1);
  localparam int EW = (CW > K_BITS) ? CW : K_BITS;

  logic [ST_BITS-1:0]  state;
  logic [K_BITS-1:0]   k_target;
  logic [CW-1:0]       count;
  logic [CW-1:0]       pos;
  logic [VW-1:0]       val;
  logic                pre;
  logic [VW-1:0]       root;
  logic [VW-1:0]       least_val;
  logic [SEL_BITS-1:0] least_sel;

  logic [EW-1:0]       k_ext;
  logic [CW-1:0]       k_eff;
  logic [CW-1:0]       pos_m1;
  logic [CW-1:0]       parent;
  logic [CW:0]         left;
  logic [CW:0]         right;
  logic [CW:0]         n_ext;
  logic                left_ok;
  logic                right_ok;
  logic [VW-1:0]       in_val;

  logic                ram_we;
  logic [VW-1:0]       ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [VW-1:0]       ram_rdata;

  logic [VW-1:0]       cmp_a;
  logic [VW-1:0]       cmp_b;
  logic                cmp_lt;
  logic [VW-1:0]       cmp_least;

  logic                out_free;

  // effective rank: zero reads as one, large values saturate
  always_comb begin
    k_ext = EW'(k_target);
    if (k_ext == '0) begin
      k_eff = CW'(1);
    end else if (k_ext > EW'(MAX_RANK)) begin
      k_eff = CW'(MAX_RANK);
    end else begin
      k_eff = k_ext[CW-1:0];
    end
  end

  // heap index arithmetic
  always_comb begin
    pos_m1   = pos - CW'(1);
    parent   = pos_m1 >> 1;
    left     = {pos, 1'b1};
    right    = left + (CW+1)'(1);
    n_ext    = {1'b0, count};
    left_ok  = (left < n_ext);
    right_ok = (right < n_ext);
  end

  // sign bias so an unsigned compare orders signed values
  assign in_val = {~s_tdata[VW-1], s_tdata[VW-2:0]};

  // read address follows the walk
  always_comb begin
    case (state)
      ST_UP_RD, ST_UP_CMP: ram_raddr = parent[AW-1:0];
      ST_DN_RD:            ram_raddr = left[AW-1:0];
      default:             ram_raddr = right[AW-1:0];
    endcase
  end

  // operands of the shared compare unit
  always_comb begin
    case (state)
      ST_UP_CMP: begin
        cmp_a = val;
        cmp_b = ram_rdata;
      end
      ST_FULL_CMP: begin
        cmp_a = root;
        cmp_b = val;
      end
      ST_DN_L: begin
        cmp_a = ram_rdata;
        cmp_b = val;
      end
      default: begin
        cmp_a = ram_rdata;
        cmp_b = least_val;
      end
    endcase
  end

  // write port: always at the current position
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = val;
    case (state)
      ST_UP_RD: begin
        ram_we = (pos == '0);
      end
      ST_UP_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = cmp_lt ? ram_rdata : val;
      end
      ST_DN_RD: begin
        ram_we = !left_ok;
      end
      ST_DN_R: begin
        ram_we = 1'b1;
        if (right_ok && cmp_lt) begin
          ram_wdata = ram_rdata;
        end else if (least_sel == SEL_LEFT) begin
          ram_wdata = least_val;
        end else begin
          ram_wdata = val;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  kls_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_RANK),
    .AW    (AW)
  ) u_heap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kls_cmp #(
    .WIDTH (VW)
  ) u_cmp (
    .a     (cmp_a),
    .b     (cmp_b),
    .lt    (cmp_lt),
    .least (cmp_least)
  );

  assign s_tready = (state == ST_IDLE) && !rst;
  assign out_free = !m_tvalid || m_tready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      k_target <= K_BITS'(1);
    end else if (cfg_we) begin
      k_target <= cfg_wdata;
    end
  end

  // root copy tracks every write to the top of the heap
  always_ff @(posedge clk) begin
    if (ram_we && pos == '0) begin
      root <= ram_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (count < k_eff) begin
              pos   <= count;
              count <= count + CW'(1);
              state <= ST_UP_RD;
            end else begin
              state <= ST_FULL_CMP;
            end
          end
        end
        ST_UP_RD: begin
          state <= (pos == '0) ? ST_FINISH : ST_UP_CMP;
        end
        ST_UP_CMP: begin
          if (cmp_lt) begin
            pos   <= parent;
            state <= ST_UP_RD;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_FULL_CMP: begin
          pos   <= '0;
          state <= cmp_lt ? ST_DN_RD : ST_FINISH;
        end
        ST_DN_RD: begin
          state <= left_ok ? ST_DN_L : ST_FINISH;
        end
        ST_DN_L: begin
          least_val <= cmp_least;
          least_sel <= cmp_lt ? SEL_LEFT : SEL_SELF;
          state     <= ST_DN_R;
        end
        ST_DN_R: begin
          if (right_ok && cmp_lt) begin
            pos   <= right[CW-1:0];
            state <= ST_DN_RD;
          end else if (least_sel == SEL_LEFT) begin
            pos   <= left[CW-1:0];
            state <= ST_DN_RD;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (pre || out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // capture of the accepted item
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      val <= in_val;
      pre <= s_tuser;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && !pre && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && !pre && out_free) begin
      m_tdata <= DW'({~root[VW-1], root[VW-2:0]});
      m_tuser <= (count >= k_eff);
    end
  end

endmodule

`default_nettype wire
